// File: src/mfd_pkg.sv
// Shared constants, register codes and types of the multi-turn feedback decoder.
package mfd_pkg;

  localparam int ENCODER_COUNTS = 8192;
  localparam int ENC_W          = $clog2(ENCODER_COUNTS);
  localparam int DELTA_W        = ENC_W + 1;
  localparam int ID_W           = 11;
  localparam int DPC_W          = 24;
  localparam int PROD_W         = DELTA_W + DPC_W + 1;
  localparam int ANGLE_W        = 48;
  localparam int BYTE_W         = 8;
  localparam int WORD_W         = 16;
  localparam int POS_W          = 13;
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 32;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [ID_W-1:0]   MOTOR_ID_RST      = ID_W'(517);
  localparam logic [DPC_W-1:0]  DEG_PER_COUNT_RST = DPC_W'(737280);
  localparam logic [BYTE_W-1:0] TEMP_LIMIT_RST    = BYTE_W'(80);
  localparam logic [BYTE_W-1:0] ERR_LIMIT_RST     = BYTE_W'(200);

  typedef enum logic [1:0] {
    REG_MOTOR_ID,
    REG_DEG_PER_COUNT,
    REG_TEMP_LIMIT,
    REG_ERR_COUNT_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic [ID_W-1:0]   motor_id;
    logic [DPC_W-1:0]  degrees_per_count;
    logic [BYTE_W-1:0] temp_limit;
    logic [BYTE_W-1:0] error_count_limit;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]        temperature;
    logic signed [WORD_W-1:0] velocity;
    logic signed [WORD_W-1:0] current;
    logic [POS_W-1:0]         encoder_position;
    logic signed [PROD_W-1:0] product;
    logic                     over_temperature;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// File: src/mfd_in_if.sv
// Feedback frame request channel.
interface mfd_in_if;
  logic                          valid;
  logic                          ready;
  logic [mfd_pkg::ID_W-1:0]      can_id;
  logic [mfd_pkg::BYTE_W-1:0]    encoder_high;
  logic [mfd_pkg::BYTE_W-1:0]    encoder_low;
  logic [mfd_pkg::BYTE_W-1:0]    velocity_high;
  logic [mfd_pkg::BYTE_W-1:0]    velocity_low;
  logic [mfd_pkg::BYTE_W-1:0]    current_high;
  logic [mfd_pkg::BYTE_W-1:0]    current_low;
  logic [mfd_pkg::BYTE_W-1:0]    temperature_byte;

  modport source (
    output valid, can_id, encoder_high, encoder_low, velocity_high, velocity_low,
           current_high, current_low, temperature_byte,
    input  ready
  );
  modport sink (
    input  valid, can_id, encoder_high, encoder_low, velocity_high, velocity_low,
           current_high, current_low, temperature_byte,
    output ready
  );
endinterface

// File: src/mfd_out_if.sv
// Decoded feedback result channel.
interface mfd_out_if;
  logic                                valid;
  logic                                ready;
  logic [mfd_pkg::BYTE_W-1:0]          temperature;
  logic signed [mfd_pkg::WORD_W-1:0]   velocity;
  logic signed [mfd_pkg::WORD_W-1:0]   current;
  logic [mfd_pkg::POS_W-1:0]           encoder_position;
  logic signed [mfd_pkg::ANGLE_W-1:0]  total_angle;
  logic                                over_temperature;

  modport source (
    output valid, temperature, velocity, current, encoder_position, total_angle,
           over_temperature,
    input  ready
  );
  modport sink (
    input  valid, temperature, velocity, current, encoder_position, total_angle,
           over_temperature,
    output ready
  );
endinterface

// File: src/motor_feedback_multiturn_decoder_top.sv
// A matching frame is registered in the queue and then in the back end's output register before it shows on out_ch.
// Throughput: one frame per cycle while out_ch accepts results; the accumulator add/saturate loop sets the pace.
// The front end stalls only when the QUEUE_DEPTH-entry queue is full.
// Frames with a foreign identifier are dropped and produce no result.
// Reset (rst_n low, synchronous) restores register defaults, clears the angle,
// temperature monitor and seed state; no clearing pass is needed.
module motor_feedback_multiturn_decoder_top #(
  parameter int QUEUE_DEPTH = mfd_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mfd_in_if.sink                           in_ch,
  mfd_out_if.source                        out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [mfd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [mfd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [mfd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  mfd_pkg::cfg_t        cfg_r;
  mfd_pkg::reg_idx_t    reg_idx;
  logic                 cfg_wr;
  logic                 push;
  logic                 pop;
  mfd_pkg::entry_t      push_data;
  mfd_pkg::entry_t      head;
  mfd_pkg::queue_stat_t q_stat;

  assign cfg_pready = 1'b1;
  assign reg_idx    = mfd_pkg::reg_idx_t'(cfg_paddr[mfd_pkg::CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motor_id          <= mfd_pkg::MOTOR_ID_RST;
      cfg_r.degrees_per_count <= mfd_pkg::DEG_PER_COUNT_RST;
      cfg_r.temp_limit        <= mfd_pkg::TEMP_LIMIT_RST;
      cfg_r.error_count_limit <= mfd_pkg::ERR_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mfd_pkg::REG_MOTOR_ID:
          cfg_r.motor_id <= cfg_pwdata[mfd_pkg::ID_W-1:0];
        mfd_pkg::REG_DEG_PER_COUNT:
          cfg_r.degrees_per_count <= cfg_pwdata[mfd_pkg::DPC_W-1:0];
        mfd_pkg::REG_TEMP_LIMIT:
          cfg_r.temp_limit <= cfg_pwdata[mfd_pkg::BYTE_W-1:0];
        mfd_pkg::REG_ERR_COUNT_LIMIT:
          cfg_r.error_count_limit <= cfg_pwdata[mfd_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mfd_pkg::REG_MOTOR_ID:
        cfg_prdata = mfd_pkg::CFG_DATA_W'(cfg_r.motor_id);
      mfd_pkg::REG_DEG_PER_COUNT:
        cfg_prdata = mfd_pkg::CFG_DATA_W'(cfg_r.degrees_per_count);
      mfd_pkg::REG_TEMP_LIMIT:
        cfg_prdata = mfd_pkg::CFG_DATA_W'(cfg_r.temp_limit);
      mfd_pkg::REG_ERR_COUNT_LIMIT:
        cfg_prdata = mfd_pkg::CFG_DATA_W'(cfg_r.error_count_limit);
      default:
        cfg_prdata = '0;
    endcase
  end

  mfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  mfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  mfd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // over-temperature is sticky across successive results
  a_ot_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.over_temperature) |=> (!out_ch.valid || out_ch.over_temperature))
    else $error("over_temperature dropped after being raised");

  // a foreign-id request with nothing in flight yields no result
  a_foreign_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.can_id != cfg_r.motor_id)
     && q_stat.empty && !out_ch.valid) |=> !out_ch.valid)
    else $error("result produced for foreign identifier");

  // a matching request lands in the queue
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !q_stat.empty || out_ch.valid)
    else $error("accepted frame lost between front and back");

  // queue never reports full and empty together
  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

endmodule

// File: src/mfd_front.sv
// Front end: id filter, temperature monitor, encoder unwrap and delta scaling.
module mfd_front (
  input  logic                clk,
  input  logic                rst_n,
  mfd_in_if.sink              in_ch,
  input  mfd_pkg::cfg_t       cfg,
  input  mfd_pkg::queue_stat_t q_stat,
  output logic                push,
  output mfd_pkg::entry_t     push_data
);

  localparam logic signed [mfd_pkg::DELTA_W:0] COUNTS_X =
    (mfd_pkg::DELTA_W + 1)'(mfd_pkg::ENCODER_COUNTS);

  logic                                seeded_r, seeded_nxt;
  logic [mfd_pkg::ENC_W-1:0]           prev_r, prev_nxt;
  logic [mfd_pkg::BYTE_W-1:0]          hot_cnt_r, hot_cnt_nxt;
  logic                                latch_r, latch_nxt;

  logic                                accept;
  logic                                match;
  logic [mfd_pkg::WORD_W-1:0]          enc_word;
  logic [mfd_pkg::ENC_W-1:0]           pos;
  logic [mfd_pkg::ENC_W-1:0]           prev_eff;
  logic signed [mfd_pkg::DELTA_W-1:0]  d;
  logic signed [mfd_pkg::DELTA_W:0]    d_x;
  logic signed [mfd_pkg::DELTA_W:0]    alt_x;
  logic signed [mfd_pkg::DELTA_W-1:0]  alt;
  logic [mfd_pkg::DELTA_W-1:0]         mag_d;
  logic [mfd_pkg::DELTA_W-1:0]         mag_alt;
  logic signed [mfd_pkg::DELTA_W-1:0]  delta;
  logic [mfd_pkg::BYTE_W-1:0]          hot_inc;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign match       = (in_ch.can_id == cfg.motor_id);
  assign push        = accept && match;

  assign enc_word = {in_ch.encoder_high, in_ch.encoder_low};
  assign pos      = enc_word[mfd_pkg::ENC_W-1:0];
  // first frame after reset seeds itself, so its delta is zero
  assign prev_eff = seeded_r ? prev_r : pos;
  assign d        = $signed({1'b0, pos}) - $signed({1'b0, prev_eff});
  assign d_x      = {d[mfd_pkg::DELTA_W-1], d};

  always_comb begin
    priority if (d > 0) begin
      alt_x = d_x - COUNTS_X;
    end else if (d < 0) begin
      alt_x = d_x + COUNTS_X;
    end else begin
      alt_x = '0;
    end
  end

  assign alt     = alt_x[mfd_pkg::DELTA_W-1:0];
  assign mag_d   = d[mfd_pkg::DELTA_W-1] ? -d : d;
  assign mag_alt = alt[mfd_pkg::DELTA_W-1] ? -alt : alt;
  // half-turn tie goes to the wrapped direction
  assign delta   = (mag_alt > mag_d) ? d : alt;

  assign hot_inc = (&hot_cnt_r) ? hot_cnt_r : hot_cnt_r + 1'b1;

  always_comb begin
    seeded_nxt  = seeded_r;
    prev_nxt    = prev_r;
    hot_cnt_nxt = hot_cnt_r;
    latch_nxt   = latch_r;
    if (push) begin
      seeded_nxt = 1'b1;
      prev_nxt   = pos;
      if (in_ch.temperature_byte > cfg.temp_limit) begin
        if (hot_inc > cfg.error_count_limit) begin
          hot_cnt_nxt = '0;
          latch_nxt   = 1'b1;
        end else begin
          hot_cnt_nxt = hot_inc;
        end
      end else begin
        hot_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r  <= 1'b0;
      prev_r    <= '0;
      hot_cnt_r <= '0;
      latch_r   <= 1'b0;
    end else begin
      seeded_r  <= seeded_nxt;
      prev_r    <= prev_nxt;
      hot_cnt_r <= hot_cnt_nxt;
      latch_r   <= latch_nxt;
    end
  end

  always_comb begin
    push_data.temperature      = in_ch.temperature_byte;
    push_data.velocity         = $signed({in_ch.velocity_high, in_ch.velocity_low});
    push_data.current          = $signed({in_ch.current_high, in_ch.current_low});
    push_data.encoder_position = mfd_pkg::POS_W'(pos);
    push_data.product          = delta * $signed({1'b0, cfg.degrees_per_count});
    push_data.over_temperature = latch_nxt;
  end

endmodule

// File: src/mfd_queue.sv
// Small FIFO between front end and accumulator.
module mfd_queue #(
  parameter int DEPTH = mfd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mfd_pkg::entry_t      push_data,
  input  logic                 pop,
  output mfd_pkg::entry_t      head,
  output mfd_pkg::queue_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  mfd_pkg::entry_t   mem [DEPTH];
  mfd_pkg::entry_t   head_r;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = head_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // head tracks the next read slot; a push into that slot is forwarded
  always_ff @(posedge clk) begin
    if (do_push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_data;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

endmodule

// File: src/mfd_back.sv
// Back end: saturating angle accumulator and output register.
module mfd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mfd_pkg::entry_t      head,
  input  mfd_pkg::queue_stat_t q_stat,
  output logic                 pop,
  mfd_out_if.source            out_ch
);

  localparam int SUM_W = mfd_pkg::ANGLE_W + 1;

  logic                                out_valid_r;
  logic signed [mfd_pkg::ANGLE_W-1:0]  acc_r, acc_nxt;
  mfd_pkg::entry_t                     res_r;
  logic signed [SUM_W-1:0]             sum;
  logic                                load;

  assign load = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign pop  = load;

  assign sum = $signed({acc_r[mfd_pkg::ANGLE_W-1], acc_r})
             + $signed({{(SUM_W - mfd_pkg::PROD_W){head.product[mfd_pkg::PROD_W-1]}},
                        head.product});

  always_comb begin
    priority if (sum[SUM_W-1] == sum[SUM_W-2]) begin
      acc_nxt = sum[mfd_pkg::ANGLE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      acc_nxt = {1'b1, {(mfd_pkg::ANGLE_W-1){1'b0}}};
    end else begin
      acc_nxt = {1'b0, {(mfd_pkg::ANGLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        acc_r       <= acc_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= head;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.temperature      = res_r.temperature;
  assign out_ch.velocity         = res_r.velocity;
  assign out_ch.current          = res_r.current;
  assign out_ch.encoder_position = res_r.encoder_position;
  assign out_ch.total_angle      = acc_r;
  assign out_ch.over_temperature = res_r.over_temperature;

endmodule
